// ===== hw/rtl/json_stream_reindenter_macros.svh =====
// ---------------------------------------------------------------------------
// JSON stream reindenter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef JSON_STREAM_REINDENTER_MACROS_SVH
`define JSON_STREAM_REINDENTER_MACROS_SVH

// same-cycle implication
`define JSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jsr_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON stream reindenter package
// Widths, character codes, result record type and small helpers.
// ---------------------------------------------------------------------------
package jsr_pkg;

  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned COUNT_W = 21;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH   = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 21'h1FFFFF;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 21'd65536;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic KIND_LIT = 1'b0;
  localparam logic KIND_LB  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] val;
    logic [7:0] spaces;
  } res_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] c, logic [7:0] k);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + {{(COUNT_W-7){1'b0}}, k};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/jsr_if.sv =====
// ---------------------------------------------------------------------------
// JSON stream reindenter channels
// Valid/ready channels for input bytes, result words and the limit register.
// ---------------------------------------------------------------------------
interface jsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface jsr_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [7:0] indent_spaces;
  logic       run_last;

  modport source (output valid, output out_kind, output out_byte,
                  output indent_spaces, output run_last, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input indent_spaces, input run_last, output ready);
endinterface

interface jsr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [jsr_pkg::COUNT_W-1:0] output_limit;

  modport source (output valid, output output_limit, input ready);
  modport sink   (input valid, input output_limit, output ready);
endinterface

// ===== hw/rtl/json_stream_reindenter.sv =====
// ---------------------------------------------------------------------------
// JSON stream reindenter
// Re-indents a JSON byte stream: string tracking, nesting depth, empty
// containers kept on one line, output byte limit.
// ---------------------------------------------------------------------------
// A byte is taken into an input register, then in one step turned into up to
// three result words held in a result buffer. A byte yielding zero or one
// word keeps the rate at one byte per clock while out_chan is ready; one
// yielding more holds the result buffer until its last word is taken, the
// next byte waiting in the input register. Words are offered from the result
// buffer. run_last flags the last word of each byte. cfg_chan is always ready.
`include "json_stream_reindenter_macros.svh"

module json_stream_reindenter (
  input logic          clk,
  input logic          rst_n,
  jsr_in_if.sink       in_chan,
  jsr_out_if.source    out_chan,
  jsr_cfg_if.sink      cfg_chan
);
  import jsr_pkg::*;

  // input register
  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;

  // stream state
  logic [DEPTH_W-1:0] depth_r;
  logic               str_r;
  logic               esc_r;
  logic               pend_r;
  logic               brace_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] limit_r;

  // result buffer
  res_t              res_q_r [3];
  logic [1:0]        res_cnt_r;
  logic [1:0]        res_idx_r;

  // step outputs
  res_t               res_nxt [3];
  logic [1:0]         n_nxt;
  logic [DEPTH_W-1:0] depth_nxt;
  logic               str_nxt;
  logic               esc_nxt;
  logic               pend_nxt;
  logic               brace_nxt;
  logic [COUNT_W-1:0] cnt_nxt;

  logic in_fire, out_fire, idx_last, move;

  function automatic res_t mk_lit(logic [7:0] b);
    res_t r;
    r.kind   = KIND_LIT;
    r.val    = b;
    r.spaces = 8'd0;
    return r;
  endfunction

  function automatic res_t mk_lb(logic [DEPTH_W-1:0] d);
    res_t r;
    r.kind   = KIND_LB;
    r.val    = CH_LF;
    r.spaces = {d, 1'b0};
    return r;
  endfunction

  assign idx_last = (res_idx_r == res_cnt_r - 2'd1);
  assign out_fire = out_chan.valid && out_chan.ready;
  assign move     = in_valid_r && ((res_cnt_r == 2'd0) || (out_fire && idx_last));
  assign in_fire  = in_chan.valid && in_chan.ready;

  assign in_chan.ready  = !in_valid_r || move;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = (res_cnt_r != 2'd0);
  assign out_chan.out_kind      = res_q_r[res_idx_r].kind;
  assign out_chan.out_byte      = res_q_r[res_idx_r].val;
  assign out_chan.indent_spaces = res_q_r[res_idx_r].spaces;
  assign out_chan.run_last      = idx_last;

  always_comb begin : step_comb
    logic       consumed;
    logic [7:0] b;
    b         = in_byte_r;
    consumed  = 1'b0;
    n_nxt     = 2'd0;
    depth_nxt = depth_r;
    str_nxt   = str_r;
    esc_nxt   = esc_r;
    pend_nxt  = pend_r;
    brace_nxt = brace_r;
    cnt_nxt   = cnt_r;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = '0;
    end

    // pending opener: whitespace waits, matching closer stays inline
    if (pend_nxt) begin
      if (is_ws(b)) begin
        consumed = 1'b1;
      end else if (b == (brace_nxt ? CH_RBRACE : CH_RBRACK)) begin
        res_nxt[n_nxt] = mk_lit(b);
        n_nxt          = n_nxt + 2'd1;
        cnt_nxt        = sat_add(cnt_nxt, 8'd1);
        pend_nxt       = 1'b0;
        consumed       = 1'b1;
      end else begin
        if (depth_nxt < MAX_DEPTH) depth_nxt = depth_nxt + 7'd1;
        res_nxt[n_nxt] = mk_lb(depth_nxt);
        n_nxt          = n_nxt + 2'd1;
        cnt_nxt        = sat_add(cnt_nxt, {depth_nxt, 1'b1});
        pend_nxt       = 1'b0;
      end
    end

    if (!consumed && (cnt_nxt < limit_r)) begin
      if (str_nxt) begin
        res_nxt[n_nxt] = mk_lit(b);
        n_nxt          = n_nxt + 2'd1;
        cnt_nxt        = sat_add(cnt_nxt, 8'd1);
        if (esc_nxt) esc_nxt = 1'b0;
        else if (b == CH_BSLASH) esc_nxt = 1'b1;
        else if (b == CH_QUOTE) str_nxt = 1'b0;
      end else begin
        case (b) inside
          CH_QUOTE: begin
            str_nxt        = 1'b1;
            res_nxt[n_nxt] = mk_lit(b);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd1);
          end
          CH_LBRACE, CH_LBRACK: begin
            res_nxt[n_nxt] = mk_lit(b);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd1);
            pend_nxt       = 1'b1;
            brace_nxt      = (b == CH_LBRACE);
          end
          CH_RBRACE, CH_RBRACK: begin
            if (depth_nxt != '0) depth_nxt = depth_nxt - 7'd1;
            res_nxt[n_nxt] = mk_lb(depth_nxt);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, {depth_nxt, 1'b1});
            res_nxt[n_nxt] = mk_lit(b);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd1);
          end
          CH_COMMA: begin
            res_nxt[n_nxt] = mk_lit(b);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd1);
            res_nxt[n_nxt] = mk_lb(depth_nxt);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, {depth_nxt, 1'b1});
          end
          CH_COLON: begin
            res_nxt[n_nxt] = mk_lit(CH_COLON);
            n_nxt          = n_nxt + 2'd1;
            res_nxt[n_nxt] = mk_lit(CH_SPACE);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd2);
          end
          CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
          end
          default: begin
            res_nxt[n_nxt] = mk_lit(b);
            n_nxt          = n_nxt + 2'd1;
            cnt_nxt        = sat_add(cnt_nxt, 8'd1);
          end
        endcase
      end
    end

    // end of text: flush pending opener, then restart stream state
    if (in_last_r) begin
      if (pend_nxt) begin
        if (depth_nxt < MAX_DEPTH) depth_nxt = depth_nxt + 7'd1;
        res_nxt[n_nxt] = mk_lb(depth_nxt);
        n_nxt          = n_nxt + 2'd1;
      end
      depth_nxt = '0;
      str_nxt   = 1'b0;
      esc_nxt   = 1'b0;
      pend_nxt  = 1'b0;
      brace_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      res_cnt_r  <= 2'd0;
      res_idx_r  <= 2'd0;
      depth_r    <= '0;
      str_r      <= 1'b0;
      esc_r      <= 1'b0;
      pend_r     <= 1'b0;
      brace_r    <= 1'b0;
      cnt_r      <= '0;
      limit_r    <= LIMIT_RESET;
    end else begin
      if (cfg_chan.valid) begin
        limit_r <= cfg_chan.output_limit;
      end
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (move) begin
        in_valid_r <= 1'b0;
      end
      if (move) begin
        res_cnt_r <= n_nxt;
        res_idx_r <= 2'd0;
        depth_r   <= depth_nxt;
        str_r     <= str_nxt;
        esc_r     <= esc_nxt;
        pend_r    <= pend_nxt;
        brace_r   <= brace_nxt;
        cnt_r     <= cnt_nxt;
      end else if (out_fire) begin
        if (idx_last) begin
          res_cnt_r <= 2'd0;
          res_idx_r <= 2'd0;
        end else begin
          res_idx_r <= res_idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_chan.in_byte;
      in_last_r <= in_chan.last_byte;
    end
    if (move) begin
      for (int i = 0; i < 3; i++) begin
        res_q_r[i] <= res_nxt[i];
      end
    end
  end

  `JSR_ASSERT_IMPL(a_idx_range, res_cnt_r != 2'd0, res_idx_r < res_cnt_r,
                   "result index beyond count")
  `JSR_ASSERT_IMPL(a_depth_cap, 1'b1, depth_r <= MAX_DEPTH, "nesting depth above cap")
  `JSR_ASSERT_NEXT(a_last_clears, move && in_last_r,
                   (depth_r == '0) && !pend_r && !str_r && (cnt_r == '0),
                   "stream state not cleared after last byte")
  `JSR_ASSERT_NEXT(a_hold_word, out_chan.valid && !out_chan.ready,
                   $stable(res_idx_r) && out_chan.valid, "stalled word moved")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// JSON stream reindenter testbench
// Drives byte streams through the input channel, predicts every result word
// with a local model of the reindenter and checks the words in order. A short
// table of directed bytes is followed by random JSON texts under several
// output limits and flow-control patterns, including one long output stall.
// ---------------------------------------------------------------------------
module tb_top;
  import jsr_pkg::*;

  typedef struct {
    logic       kind;
    logic [7:0] val;
    logic [7:0] spaces;
    logic       last;
  } word_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    bit         typed;
    logic       kind;
    logic [7:0] val;
    logic [7:0] spaces;
  } row_t;

  typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

  typedef struct {
    logic [COUNT_W-1:0] lim;
    flow_t              flow;
    int                 budget;
    bit                 deep;
    bit                 hold;
  } phase_t;

  localparam int N_DIR    = 24;
  localparam int N_PHASE  = 6;
  localparam int HOLD_LEN = 200;

  logic clk;
  logic rst_n;

  jsr_in_if  in_if ();
  jsr_out_if out_if ();
  jsr_cfg_if cfg_if ();

  json_stream_reindenter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // reindenter state as predicted
  logic [DEPTH_W-1:0] depth      = '0;
  logic               in_str     = 1'b0;
  logic               escaped    = 1'b0;
  logic               pend       = 1'b0;
  logic               pend_brace = 1'b0;
  logic [COUNT_W-1:0] emitted    = '0;
  logic [COUNT_W-1:0] out_limit  = LIMIT_RESET;

  word_t      byte_words [$];
  word_t      words_due [$];
  logic [7:0] text_buf [$];

  int errors    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  logic [7:0] marks [8] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                            CH_COMMA, CH_COLON, CH_QUOTE, CH_BSLASH};

  row_t dir_rows [N_DIR] = '{
    '{8'h00,     1'b0, 1'b1, KIND_LIT, 8'h00,     8'd0},
    '{8'hFF,     1'b0, 1'b1, KIND_LIT, 8'hFF,     8'd0},
    '{CH_LBRACE, 1'b0, 1'b1, KIND_LIT, CH_LBRACE, 8'd0},
    '{CH_SPACE,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_RBRACE, 1'b0, 1'b1, KIND_LIT, CH_RBRACE, 8'd0},
    '{CH_LBRACK, 1'b0, 1'b1, KIND_LIT, CH_LBRACK, 8'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_COLON,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_COLON,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_TAB,    1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_COMMA,  1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_LBRACK, 1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_RBRACE, 1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_RBRACK, 1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_RBRACK, 1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_CR,     1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_LF,     1'b0, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_LBRACE, 1'b1, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{CH_LF,     1'b1, 1'b0, KIND_LIT, 8'h00,     8'd0},
    '{8'h61,     1'b0, 1'b1, KIND_LIT, 8'h61,     8'd0},
    '{CH_LBRACK, 1'b1, 1'b0, KIND_LIT, 8'h00,     8'd0}
  };

  phase_t phases [N_PHASE] = '{
    '{21'd1048576, FLOW_FREE,      12, 1'b0, 1'b0},
    '{21'd0,       FLOW_SRC_IDLE,   8, 1'b0, 1'b0},
    '{21'd1,       FLOW_SNK_STALL, 10, 1'b0, 1'b0},
    '{COUNT_MAX,   FLOW_BOTH,       8, 1'b1, 1'b0},
    '{21'd25,      FLOW_BOTH,      12, 1'b0, 1'b0},
    '{LIMIT_RESET, FLOW_SNK_STALL, 12, 1'b0, 1'b1}
  };

  // ---- predictor ----------------------------------------------------------

  function automatic bit is_layout(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic void add_count(logic [8:0] k);
    logic [COUNT_W:0] s;
    s = {1'b0, emitted} + k;
    emitted = s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

  function automatic void emit_lit(logic [7:0] b);
    byte_words.push_back('{KIND_LIT, b, 8'd0, 1'b0});
    add_count(9'd1);
  endfunction

  function automatic void emit_break();
    logic [7:0] sp;
    sp = {depth, 1'b0};
    byte_words.push_back('{KIND_LB, CH_LF, sp, 1'b0});
    add_count(9'd1 + sp);
  endfunction

  function automatic void raise_level();
    if (depth < MAX_DEPTH) depth = depth + 1'b1;
    emit_break();
    pend = 1'b0;
  endfunction

  function automatic void reindent_byte(logic [7:0] b, logic l);
    logic [7:0] closer;
    bit         taken;
    byte_words.delete();
    taken = 1'b0;
    if (pend) begin
      closer = pend_brace ? CH_RBRACE : CH_RBRACK;
      if (is_layout(b)) begin
        taken = 1'b1;
      end else if (b == closer) begin
        emit_lit(b);
        pend  = 1'b0;
        taken = 1'b1;
      end else begin
        raise_level();
      end
    end
    if (!taken && emitted < out_limit) begin
      if (in_str) begin
        emit_lit(b);
        if (escaped) escaped = 1'b0;
        else if (b == CH_BSLASH) escaped = 1'b1;
        else if (b == CH_QUOTE) in_str = 1'b0;
      end else begin
        case (b)
          CH_QUOTE: begin
            in_str = 1'b1;
            emit_lit(b);
          end
          CH_LBRACE, CH_LBRACK: begin
            emit_lit(b);
            pend       = 1'b1;
            pend_brace = (b == CH_LBRACE);
          end
          CH_RBRACE, CH_RBRACK: begin
            if (depth > 0) depth = depth - 1'b1;
            emit_break();
            emit_lit(b);
          end
          CH_COMMA: begin
            emit_lit(b);
            emit_break();
          end
          CH_COLON: begin
            emit_lit(CH_COLON);
            emit_lit(CH_SPACE);
          end
          CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
          default: emit_lit(b);
        endcase
      end
    end
    if (l) begin
      if (pend) raise_level();
      depth      = '0;
      in_str     = 1'b0;
      escaped    = 1'b0;
      pend       = 1'b0;
      pend_brace = 1'b0;
      emitted    = '0;
    end
    if (byte_words.size() > 0) byte_words[byte_words.size()-1].last = 1'b1;
  endfunction

  // ---- text generation ----------------------------------------------------

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void push_ws();
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: text_buf.push_back(CH_SPACE);
          1: text_buf.push_back(CH_TAB);
          2: text_buf.push_back(CH_LF);
          default: text_buf.push_back(CH_CR);
        endcase
      end
    end
  endfunction

  function automatic void push_string();
    logic [7:0] c;
    int         r;
    text_buf.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        text_buf.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: text_buf.push_back(CH_QUOTE);
          1: text_buf.push_back(CH_BSLASH);
          default: text_buf.push_back(8'h6E);
        endcase
      end else if (r < 25) begin
        c = 8'($urandom_range(8'h80, 8'hFF));
        text_buf.push_back(c);
      end else begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h78;
        text_buf.push_back(c);
      end
    end
    text_buf.push_back(CH_QUOTE);
  endfunction

  function automatic void push_scalar();
    case ($urandom_range(0, 3))
      0: push_string();
      1: repeat ($urandom_range(1, 4)) text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
      2: push_str("true");
      default: push_str("null");
    endcase
  endfunction

  // mostly well-formed JSON, some raw noise and cut-off texts
  function automatic void gen_text();
    logic [7:0] closers [$];
    bit         need;
    int         steps;
    int         r;
    int         cut;
    text_buf.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(0, 255)));
        else text_buf.push_back(marks[$urandom_range(0, 7)]);
      end
      return;
    end
    need  = 1'b1;
    steps = $urandom_range(2, 14);
    for (int i = 0; i < steps; i++) begin
      push_ws();
      if (need) begin
        r = $urandom_range(0, 99);
        if (r < 35 && closers.size() < 5) begin
          if ($urandom_range(0, 1)) begin
            text_buf.push_back(CH_LBRACE);
            closers.push_back(CH_RBRACE);
            push_ws();
            push_string();
            text_buf.push_back(CH_COLON);
          end else begin
            text_buf.push_back(CH_LBRACK);
            closers.push_back(CH_RBRACK);
          end
        end else if (r < 45) begin
          if ($urandom_range(0, 1)) begin
            text_buf.push_back(CH_LBRACE);
            push_ws();
            text_buf.push_back(CH_RBRACE);
          end else begin
            text_buf.push_back(CH_LBRACK);
            push_ws();
            text_buf.push_back(CH_RBRACK);
          end
          need = 1'b0;
        end else begin
          push_scalar();
          need = 1'b0;
        end
      end else if (closers.size() == 0) begin
        break;
      end else if ($urandom_range(0, 99) < 55) begin
        text_buf.push_back(CH_COMMA);
        if (closers[closers.size()-1] == CH_RBRACE) begin
          push_ws();
          push_string();
          text_buf.push_back(CH_COLON);
        end
        need = 1'b1;
      end else begin
        text_buf.push_back(closers.pop_back());
      end
    end
    if (need) push_scalar();
    while (closers.size() > 0) begin
      push_ws();
      text_buf.push_back(closers.pop_back());
    end
    push_ws();
    if ($urandom_range(0, 99) < 15 && text_buf.size() > 1) begin
      cut = $urandom_range(1, text_buf.size() - 1);
      while (text_buf.size() > cut) void'(text_buf.pop_back());
    end
  endfunction

  // ---- channel drivers ----------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_word(input logic [7:0] b, input logic l, input bit typed,
                           input word_t fixed);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.last_byte <= l;
    do @(posedge clk); while (!in_if.ready);
    reindent_byte(b, l);
    if (typed) words_due.push_back(fixed);
    else foreach (byte_words[i]) words_due.push_back(byte_words[i]);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) begin
      send_word(text_buf[i], i == text_buf.size() - 1, 1'b0,
                '{1'b0, 8'd0, 8'd0, 1'b0});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int held;
    held = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        held++;
        if (held >= HOLD_LEN) hold_done = 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: out_kind %0d out_byte %0h indent_spaces %0d",
               out_if.out_kind, out_if.out_byte, out_if.indent_spaces);
        errors++;
      end else begin
        want = words_due.pop_front();
        if (out_if.out_kind !== want.kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, out_if.out_kind);
          errors++;
        end
        if (out_if.out_byte !== want.val) begin
          $error("out_byte: expected %0h, actual %0h", want.val, out_if.out_byte);
          errors++;
        end
        if (out_if.indent_spaces !== want.spaces) begin
          $error("indent_spaces: expected %0d, actual %0d", want.spaces,
                 out_if.indent_spaces);
          errors++;
        end
        if (out_if.run_last !== want.last) begin
          $error("run_last: expected %0d, actual %0d", want.last, out_if.run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("json_stream_reindenter: mismatch");
    $finish;
  end

  // ---- main sequence ------------------------------------------------------

  initial begin
    int sent;
    in_if.valid          = 1'b0;
    in_if.in_byte        = '0;
    in_if.last_byte      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.output_limit  = '0;
    rst_n                = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed,
                '{dir_rows[i].kind, dir_rows[i].val, dir_rows[i].spaces, 1'b1});
    end

    foreach (phases[p]) begin
      drain();
      @(negedge clk);
      cfg_if.valid        <= 1'b1;
      cfg_if.output_limit <= phases[p].lim;
      do @(posedge clk); while (!cfg_if.ready);
      out_limit = phases[p].lim;
      @(negedge clk);
      cfg_if.valid <= 1'b0;

      case (phases[p].flow)
        FLOW_FREE:      begin idle_pct = 0;  stall_pct = 0;  end
        FLOW_SRC_IDLE:  begin idle_pct = 63; stall_pct = 0;  end
        FLOW_SNK_STALL: begin idle_pct = 0;  stall_pct = 63; end
        default:        begin idle_pct = 33; stall_pct = 33; end
      endcase
      hold_req = phases[p].hold;

      // nesting past the depth cap
      if (phases[p].deep) begin
        text_buf.delete();
        repeat (66) text_buf.push_back(CH_LBRACK);
        text_buf.push_back(8'h37);
        repeat (4) text_buf.push_back(CH_RBRACK);
        send_text();
      end

      sent = 0;
      while (sent < phases[p].budget) begin
        gen_text();
        send_text();
        sent += text_buf.size();
      end
    end

    drain();
    if (errors == 0) begin
      $display("json_stream_reindenter: match");
    end else begin
      $display("json_stream_reindenter: mismatch");
    end
    $finish;
  end

endmodule

// ===== json_stream_reindenter.f =====
+incdir+hw/rtl
hw/rtl/jsr_pkg.sv
hw/rtl/jsr_if.sv
hw/rtl/json_stream_reindenter.sv
test/tb_top.sv
